/* rtl/fifo_flow_slack_stamper_unit_defines.svh */
// Assertion macros used by the verification-only checker of the slack stamper.
// Depends on nothing; the including file supplies clock, reset and expressions.
`ifndef FIFO_FLOW_SLACK_STAMPER_UNIT_DEFINES_SVH
`define FIFO_FLOW_SLACK_STAMPER_UNIT_DEFINES_SVH

// Same-cycle implication, quiet while reset is high.
`define FFSS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define FFSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/ffss_pkg.sv */
// Shared widths, defaults and codes of the FIFO flow slack stamper.
// Used by the top level and by its checker; depends on nothing.
package ffss_pkg;

   localparam int TAG_W       = 16;
   localparam int FLOW_W      = 8;
   localparam int SIZE_W      = 16;
   localparam int COUNT_W     = 7;
   localparam int BYTES_W     = 22;
   localparam int INTER_W     = 32;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 1;

   localparam int QUEUE_DEPTH_DEFAULT = 64;
   localparam int FLOW_COUNT_DEFAULT  = 256;
   localparam int TIME_BITS_DEFAULT   = 48;

   localparam logic [COUNT_W-1:0] QUEUE_LIMIT_RESET = 7'd50;
   localparam logic [INTER_W-1:0] INTER_SLACK_RESET = 32'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_QUEUE_LIMIT = 1'b0,
      CSR_INTER_SLACK = 1'b1
   } csr_index_type;

   typedef enum logic {
      ACTION_ENQUEUE = 1'b0,
      ACTION_DEQUEUE = 1'b1
   } action_type;

endpackage

/* rtl/fifo_flow_slack_stamper_unit.sv */
// Packet FIFO with per-flow slack stamping on departure; uses ffss_pkg.
// An accepted request moves from stage one through stage two to the response register.
// Throughput: one request per cycle; only a stalled response holds the pipeline back.
// The per-flow table is a memory read one stage ahead of its write, bridged by a bypass.
// Reset is synchronous and active high: empty FIFO, zero counts, all flows unseen,
// queue_limit back to 50 and inter_slack to 0. No clearing pass is needed.
module fifo_flow_slack_stamper_unit
   import ffss_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
   parameter int FLOW_COUNT  = FLOW_COUNT_DEFAULT,
   parameter int TIME_BITS   = TIME_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_action,
   input  logic [TAG_W-1:0]       req_packet_tag,
   input  logic [FLOW_W-1:0]      req_flow_id,
   input  logic [SIZE_W-1:0]      req_packet_bytes,
   input  logic [TIME_BITS-1:0]   req_now_ns,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_dropped,
   output logic                   rsp_was_empty,
   output logic                   rsp_out_valid,
   output logic [TAG_W-1:0]       rsp_out_tag,
   output logic [FLOW_W-1:0]      rsp_out_flow,
   output logic [SIZE_W-1:0]      rsp_out_bytes,
   output logic [TIME_BITS-1:0]   rsp_out_slack,
   output logic [COUNT_W-1:0]     rsp_occupancy,
   output logic [BYTES_W-1:0]     rsp_bytes_held,

   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   // Queue storage geometry. Pointers wrap at QUEUE_DEPTH, which need not be a
   // power of two. The packet count never passes the 7-bit limit register, so
   // the effective limit is the smaller of the register and the depth.
   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam logic [QW-1:0] LAST_PTR = QW'(QUEUE_DEPTH - 1);
   localparam logic [COUNT_W-1:0] DEPTH_CAP =
      (QUEUE_DEPTH < (2 ** COUNT_W)) ? COUNT_W'(QUEUE_DEPTH) : {COUNT_W{1'b1}};

   // Flow table geometry. A flow number is reduced modulo FLOW_COUNT, and only
   // the slots that an 8-bit flow number can reach are stored.
   localparam int FLOW_SPAN  = 2 ** FLOW_W;
   localparam int FLOW_SLOTS = (FLOW_COUNT < FLOW_SPAN) ? FLOW_COUNT : FLOW_SPAN;
   localparam int FW = $clog2(FLOW_SLOTS);

   // Slack arithmetic runs three bits wider than the time field so that the
   // sum of slack, last time and the negated (now - inter_slack) never wraps.
   localparam int TW = TIME_BITS;
   localparam int SW = TIME_BITS + 3;
   localparam logic [TW-1:0] TIME_MAX = {TW{1'b1}};

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [FLOW_W-1:0] flow;
      logic [SIZE_W-1:0] size;
   } fifo_entry_type;

   typedef struct packed {
      logic [TW-1:0] slack;
      logic [TW-1:0] last_time;
   } flow_entry_type;

   // Stage one holds the queue decision made at acceptance.
   typedef struct packed {
      logic               push;
      logic               pop;
      logic               drop;
      logic               empty;
      logic [SIZE_W-1:0]  size;
      logic [TW-1:0]      now;
      logic [COUNT_W-1:0] occ;
   } stage1_type;

   // Stage two holds the departing descriptor while the flow entry is read.
   typedef struct packed {
      logic               pop;
      logic               drop;
      logic               empty;
      logic [TAG_W-1:0]   tag;
      logic [FLOW_W-1:0]  flow;
      logic [SIZE_W-1:0]  size;
      logic [FW-1:0]      idx;
      logic [TW-1:0]      now;
      logic [TW:0]        now_less_inter;
      logic [COUNT_W-1:0] occ;
      logic [BYTES_W-1:0] held;
   } stage2_type;

   // Configuration registers.
   logic [COUNT_W-1:0] queue_limit_ff, queue_limit_in;
   logic [INTER_W-1:0] inter_slack_ff, inter_slack_in;

   // Queue bookkeeping.
   logic [QW-1:0]      head_ff, head_in;
   logic [QW-1:0]      tail_ff, tail_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;

   fifo_entry_type     fifo_mem [QUEUE_DEPTH];
   fifo_entry_type     fifo_rd_ff;

   flow_entry_type     flow_mem [FLOW_SLOTS];
   flow_entry_type     flow_rd_ff;
   logic [FLOW_SLOTS-1:0] seen_ff, seen_in;

   // Copy of the most recent flow table write, used as a bypass because the
   // read for the next request happens at the same edge as that write.
   logic               wr_valid_ff, wr_valid_in;
   logic [FW-1:0]      wr_idx_ff;
   flow_entry_type     wr_entry_ff;

   logic               s1_valid_ff, s1_valid_in;
   stage1_type         s1_ff, s1_in;
   logic               s2_valid_ff, s2_valid_in;
   stage2_type         s2_ff, s2_in;

   // Response register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_dropped_ff, rsp_was_empty_ff, rsp_out_valid_ff;
   logic [TAG_W-1:0]   rsp_out_tag_ff;
   logic [FLOW_W-1:0]  rsp_out_flow_ff;
   logic [SIZE_W-1:0]  rsp_out_bytes_ff;
   logic [TW-1:0]      rsp_out_slack_ff;
   logic [COUNT_W-1:0] rsp_occupancy_ff;
   logic [BYTES_W-1:0] rsp_bytes_held_ff;

   // Constant table that reduces a flow number to its table slot.
   logic [FW-1:0]      flow_map [FLOW_SPAN];

   logic               out_free, s2_free, s2_move, s1_free, s1_move, accept;
   logic [COUNT_W-1:0] eff_limit;
   logic               is_dequeue, full, push, pop;
   logic [FW-1:0]      s1_idx;

   logic               fwd;
   flow_entry_type     cur_entry;
   logic               cur_seen;
   logic [TW:0]        budget_sum;
   logic [SW-1:0]      open_sum;
   logic [TW:0]        capped_sum;
   logic [TW-1:0]      open_slack, capped_slack, new_slack;

   for (genvar g = 0; g < FLOW_SPAN; g++) begin : g_flow_map
      assign flow_map[g] = FW'(g % FLOW_COUNT);
   end

   // Flow control. Each stage moves on when the one after it is free or is
   // moving itself, so a waiting response stalls the pipeline only once all
   // stages in front of it are full.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s2_move   = s2_valid_ff && out_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign s1_move   = s1_valid_ff && s2_free;
   assign accept    = req_valid && s1_free;
   assign req_stall = !s1_free;

   // Configuration writes.
   always_comb begin
      queue_limit_in = queue_limit_ff;
      inter_slack_in = inter_slack_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_QUEUE_LIMIT: queue_limit_in = csr_write_data[COUNT_W-1:0];
            CSR_INTER_SLACK: inter_slack_in = csr_write_data[INTER_W-1:0];
         endcase
      end
   end

   // Queue decision at acceptance. The packet count and both pointers move
   // here so that the next request in the following cycle sees them.
   always_comb begin
      eff_limit  = (queue_limit_ff < DEPTH_CAP) ? queue_limit_ff : DEPTH_CAP;
      is_dequeue = (action_type'(req_action) == ACTION_DEQUEUE);
      full       = (count_ff >= eff_limit);
      push       = accept && !is_dequeue && !full;
      pop        = accept && is_dequeue && (count_ff != '0);

      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in  = (tail_ff == LAST_PTR) ? '0 : tail_ff + QW'(1);
         count_in = count_ff + COUNT_W'(1);
      end else if (pop) begin
         head_in  = (head_ff == LAST_PTR) ? '0 : head_ff + QW'(1);
         count_in = count_ff - COUNT_W'(1);
      end

      s1_valid_in = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      s1_in.push  = push;
      s1_in.pop   = pop;
      s1_in.drop  = !is_dequeue && full;
      s1_in.empty = is_dequeue && (count_ff == '0);
      s1_in.size  = req_packet_bytes;
      s1_in.now   = req_now_ns;
      s1_in.occ   = count_in;
   end

   // Stage one: the head descriptor is available. The byte count is kept
   // here, in request order, because a departure's size is known only now.
   always_comb begin
      s1_idx   = flow_map[fifo_rd_ff.flow];
      bytes_in = bytes_ff;
      if (s1_move && s1_ff.push) begin
         bytes_in = bytes_ff + BYTES_W'(s1_ff.size);
      end else if (s1_move && s1_ff.pop) begin
         bytes_in = bytes_ff - BYTES_W'(fifo_rd_ff.size);
      end

      s2_valid_in          = s1_move ? 1'b1 : (s2_move ? 1'b0 : s2_valid_ff);
      s2_in.pop            = s1_ff.pop;
      s2_in.drop           = s1_ff.drop;
      s2_in.empty          = s1_ff.empty;
      s2_in.tag            = fifo_rd_ff.tag;
      s2_in.flow           = fifo_rd_ff.flow;
      s2_in.size           = fifo_rd_ff.size;
      s2_in.idx            = s1_idx;
      s2_in.now            = s1_ff.now;
      s2_in.now_less_inter = {1'b0, s1_ff.now} - (TW + 1)'(inter_slack_ff);
      s2_in.occ            = s1_ff.occ;
      s2_in.held           = bytes_in;
   end

   // Stage two: stamp the slack, zero for an unseen flow. Else the new slack
   // is the budget plus the last time minus now, clamped to the time field,
   // where the budget is the old slack plus inter_slack capped at the field
   // maximum. Both cases are formed side by side; the budget carry picks one.
   always_comb begin
      fwd       = wr_valid_ff && (wr_idx_ff == s2_ff.idx);
      cur_entry = fwd ? wr_entry_ff : flow_rd_ff;
      cur_seen  = seen_ff[s2_ff.idx];

      budget_sum = {1'b0, cur_entry.slack} + (TW + 1)'(inter_slack_ff);

      open_sum = {3'b000, cur_entry.slack} + {3'b000, cur_entry.last_time}
               - {{2{s2_ff.now_less_inter[TW]}}, s2_ff.now_less_inter};
      if (open_sum[SW-1]) begin
         open_slack = '0;
      end else if (|open_sum[SW-2:TW]) begin
         open_slack = TIME_MAX;
      end else begin
         open_slack = open_sum[TW-1:0];
      end

      capped_sum   = {1'b0, ~s2_ff.now} + {1'b0, cur_entry.last_time};
      capped_slack = capped_sum[TW] ? TIME_MAX : capped_sum[TW-1:0];

      if (!cur_seen) begin
         new_slack = '0;
      end else if (budget_sum[TW]) begin
         new_slack = capped_slack;
      end else begin
         new_slack = open_slack;
      end

      seen_in     = seen_ff;
      wr_valid_in = wr_valid_ff;
      if (s2_move && s2_ff.pop) begin
         seen_in[s2_ff.idx] = 1'b1;
         wr_valid_in        = 1'b1;
      end

      rsp_valid_in = s2_move ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         queue_limit_ff <= QUEUE_LIMIT_RESET;
         inter_slack_ff <= INTER_SLACK_RESET;
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
         bytes_ff       <= '0;
         seen_ff        <= '0;
         wr_valid_ff    <= 1'b0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         queue_limit_ff <= queue_limit_in;
         inter_slack_ff <= inter_slack_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         count_ff       <= count_in;
         bytes_ff       <= bytes_in;
         seen_ff        <= seen_in;
         wr_valid_ff    <= wr_valid_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Descriptor memory: written at the tail on an enqueue, read at the head
   // on a dequeue at the same edge that the request is accepted.
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[tail_ff] <= '{tag: req_packet_tag, flow: req_flow_id,
                                size: req_packet_bytes};
      end
      if (pop) begin
         fifo_rd_ff <= fifo_mem[head_ff];
      end
   end

   // Flow table memory: read as a departure enters stage two, written as it
   // leaves. The bypass register follows every write.
   always_ff @(posedge clock) begin
      if (s1_move && s1_ff.pop) begin
         flow_rd_ff <= flow_mem[s1_idx];
      end
      if (s2_move && s2_ff.pop) begin
         flow_mem[s2_ff.idx] <= '{slack: new_slack, last_time: s2_ff.now};
         wr_idx_ff           <= s2_ff.idx;
         wr_entry_ff         <= '{slack: new_slack, last_time: s2_ff.now};
      end
   end

   // Stage payloads and the response register.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_move) begin
         s2_ff <= s2_in;
      end
      if (s2_move) begin
         rsp_dropped_ff    <= s2_ff.drop;
         rsp_was_empty_ff  <= s2_ff.empty;
         rsp_out_valid_ff  <= s2_ff.pop;
         rsp_out_tag_ff    <= s2_ff.pop ? s2_ff.tag : '0;
         rsp_out_flow_ff   <= s2_ff.pop ? s2_ff.flow : '0;
         rsp_out_bytes_ff  <= s2_ff.pop ? s2_ff.size : '0;
         rsp_out_slack_ff  <= s2_ff.pop ? new_slack : '0;
         rsp_occupancy_ff  <= s2_ff.occ;
         rsp_bytes_held_ff <= s2_ff.held;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dropped    = rsp_dropped_ff;
   assign rsp_was_empty  = rsp_was_empty_ff;
   assign rsp_out_valid  = rsp_out_valid_ff;
   assign rsp_out_tag    = rsp_out_tag_ff;
   assign rsp_out_flow   = rsp_out_flow_ff;
   assign rsp_out_bytes  = rsp_out_bytes_ff;
   assign rsp_out_slack  = rsp_out_slack_ff;
   assign rsp_occupancy  = rsp_occupancy_ff;
   assign rsp_bytes_held = rsp_bytes_held_ff;

endmodule

/* rtl/ffss_checker.sv */
// Port-level checker for the slack stamper, bound to its top level.
// Depends on ffss_pkg and on fifo_flow_slack_stamper_unit_defines.svh.
`include "fifo_flow_slack_stamper_unit_defines.svh"

module ffss_checker
   import ffss_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic                 rsp_dropped,
   input logic                 rsp_was_empty,
   input logic                 rsp_out_valid,
   input logic [TIME_BITS-1:0] rsp_out_slack,
   input logic [COUNT_W-1:0]   rsp_occupancy,
   input logic [BYTES_W-1:0]   rsp_bytes_held
);

   logic               rsp_fire;
   logic [COUNT_W-1:0] last_occ_ff, last_occ_in;
   logic [COUNT_W:0]   occ_plus_one;
   logic [COUNT_W:0]   last_occ_wide;

   assign rsp_fire      = rsp_valid && !rsp_stall;
   assign occ_plus_one  = {1'b0, rsp_occupancy} + (COUNT_W + 1)'(1);
   assign last_occ_wide = {1'b0, last_occ_ff};
   assign last_occ_in   = rsp_fire ? rsp_occupancy : last_occ_ff;

   // Occupancy shown with the most recently delivered request.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_occ_ff <= '0;
      end else begin
         last_occ_ff <= last_occ_in;
      end
   end

   `FFSS_ASSERT_IMPLY(a_departure_lowers_occupancy, clock, reset, rsp_fire && rsp_out_valid, occ_plus_one == last_occ_wide, "departure did not lower the occupancy by one")
   `FFSS_ASSERT_IMPLY(a_refusal_keeps_occupancy, clock, reset, rsp_fire && (rsp_dropped || rsp_was_empty), rsp_occupancy == last_occ_ff, "drop or empty dequeue changed the occupancy")
   `FFSS_ASSERT_IMPLY(a_empty_queue_holds_no_bytes, clock, reset, rsp_valid && (rsp_occupancy == '0), rsp_bytes_held == '0, "empty queue reports bytes held")
   `FFSS_ASSERT_NEXT(a_stalled_response_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_slack) && $stable(rsp_occupancy), "stalled response changed")

endmodule

bind fifo_flow_slack_stamper_unit ffss_checker #(.TIME_BITS(TIME_BITS)) u_ffss_checker (.*);
